// ===== rtl/core/obdp_pkg.sv =====
// ---------------------------------------------------------------------------
// obdp_pkg
// Shared types, constants and decode helpers for the OBD response parser.
// ---------------------------------------------------------------------------
package obdp_pkg;

    localparam int LINE_CAP  = 64;
    localparam int LEN_W     = $clog2(LINE_CAP);
    localparam int HEAD_N    = 8;
    localparam int HEAD_IW   = $clog2(HEAD_N);
    localparam int CAPLEN_W  = $clog2(HEAD_N + 1);

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PROMPT = 8'h3E;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_PRT_LO = 8'd32;
    localparam logic [7:0] CH_PRT_HI = 8'd126;

    localparam logic [7:0] PID_RPM   = 8'h0C;
    localparam logic [7:0] PID_SPEED = 8'h0D;
    localparam logic [7:0] PID_FUEL  = 8'h2F;

    typedef enum logic [1:0] {
        EV_PROMPT = 2'd0,
        EV_RPM    = 2'd1,
        EV_SPEED  = 2'd2,
        EV_FUEL   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] rx_char;
        logic       link_live;
    } t_in_item;

    typedef struct packed {
        t_kind       event_kind;
        logic [13:0] event_value;
    } t_out_item;

    // finished line as handed from the front to the back
    typedef struct packed {
        logic [HEAD_N-1:0][7:0] head;
        logic [CAPLEN_W-1:0]    len;   // saturates at HEAD_N
        logic                   live;
    } t_line;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    typedef struct packed {
        logic       ok;
        logic [7:0] val;
    } t_pair;

    function automatic t_digit hex_digit(input logic [7:0] c);
        t_digit d;
        d.ok  = 1'b1;
        d.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.val = 4'(c - 8'h37);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    // two chars to a byte, strtol style: hex hex, sign/space + hex, or "-0"
    function automatic t_pair read_pair(input logic [7:0] c0, input logic [7:0] c1);
        t_pair  p;
        t_digit d0;
        t_digit d1;
        d0 = hex_digit(c0);
        d1 = hex_digit(c1);
        p.ok  = 1'b0;
        p.val = 8'd0;
        if (d0.ok && d1.ok) begin
            p.ok  = 1'b1;
            p.val = {d0.val, d1.val};
        end else if ((c0 == CH_SPACE || c0 == CH_PLUS) && d1.ok) begin
            p.ok  = 1'b1;
            p.val = {4'd0, d1.val};
        end else if (c0 == CH_MINUS && c1 == CH_ZERO) begin
            p.ok  = 1'b1;
        end
        return p;
    endfunction

endpackage

// ===== rtl/core/obdp_front.sv =====
// ---------------------------------------------------------------------------
// obdp_front
// Accepts characters, builds the current line and hands finished lines on.
// ---------------------------------------------------------------------------
module obdp_front
    import obdp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_data,
    input  logic     i_q_full,
    output logic     o_push,
    output t_line    o_line
);

    logic [HEAD_N-1:0][7:0] r_head;
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    logic                   w_accept;
    logic                   w_eol;
    logic                   w_print;
    logic                   w_head_we;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;

    always_comb begin
        w_eol   = (i_data.rx_char == CH_CR) || (i_data.rx_char == CH_LF);
        w_print = i_data.rx_char inside {[CH_PRT_LO:CH_PRT_HI]};
    end

    assign w_head_we = w_accept && w_print && (r_len < LEN_W'(LINE_CAP - 1))
                       && (r_len < LEN_W'(HEAD_N));

    always_comb begin
        n_len = r_len;
        if (w_accept) begin
            if (w_eol) begin
                n_len = '0;
            end else if (w_print && (r_len < LEN_W'(LINE_CAP - 1))) begin
                n_len = r_len + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            r_head[r_len[HEAD_IW-1:0]] <= i_data.rx_char;
        end
    end

    assign o_push      = w_accept && w_eol && (r_len != '0);
    assign o_line.head = r_head;
    assign o_line.live = i_data.link_live;
    assign o_line.len  = (r_len >= LEN_W'(HEAD_N)) ? CAPLEN_W'(HEAD_N)
                                                   : r_len[CAPLEN_W-1:0];

endmodule

// ===== rtl/core/obdp_fifo.sv =====
// ---------------------------------------------------------------------------
// obdp_fifo
// Two-entry queue of finished lines between the front and the back.
// ---------------------------------------------------------------------------
module obdp_fifo
    import obdp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_line i_line,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_line o_line
);

    t_line       r_mem [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_line  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_line;
        end
    end

endmodule

// ===== rtl/core/obdp_back.sv =====
// ---------------------------------------------------------------------------
// obdp_back
// Decodes a finished line into a prompt or PID event and drives the output.
// ---------------------------------------------------------------------------
module obdp_back
    import obdp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_line     i_line,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic      r_valid;
    t_out_item r_data;
    logic      w_hit;
    t_out_item w_res;
    logic      w_load;
    t_pair     w_pid;
    t_pair     w_a;
    t_pair     w_b;

    always_comb begin
        w_pid = read_pair(i_line.head[2], i_line.head[3]);
        w_a   = read_pair(i_line.head[4], i_line.head[5]);
        w_b   = read_pair(i_line.head[6], i_line.head[7]);
    end

    always_comb begin
        w_hit             = 1'b0;
        w_res.event_kind  = EV_PROMPT;
        w_res.event_value = '0;
        if (i_line.len == CAPLEN_W'(1) && i_line.head[0] == CH_PROMPT) begin
            w_hit = 1'b1;
        end else if (i_line.live && i_line.head[0] == CH_FOUR
                     && i_line.len >= CAPLEN_W'(4) && w_pid.ok) begin
            if (w_pid.val == PID_RPM) begin
                if (i_line.len >= CAPLEN_W'(8) && w_a.ok && w_b.ok) begin
                    w_hit             = 1'b1;
                    w_res.event_kind  = EV_RPM;
                    w_res.event_value = {w_a.val, w_b.val[7:2]};
                end
            end else if (w_pid.val == PID_SPEED || w_pid.val == PID_FUEL) begin
                if (i_line.len >= CAPLEN_W'(6) && w_a.ok) begin
                    w_hit             = 1'b1;
                    w_res.event_kind  = (w_pid.val == PID_SPEED) ? EV_SPEED : EV_FUEL;
                    w_res.event_value = {6'd0, w_a.val};
                end
            end
        end
    end

    assign w_load = !r_valid || !i_stall;
    // a line with no event drains even while the output is held
    assign o_pop  = i_q_valid && (!w_hit || w_load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_q_valid && w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= w_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/obd_response_line_parser_core.sv =====
// ---------------------------------------------------------------------------
// obd_response_line_parser_core
// Line parser for the text responses of an OBD-II mode 01 adapter.
//
// Input channel: one received byte plus the link-live flag per transfer.
// A transfer takes place when i_in_valid is high and o_in_stall is low.
// Output channel: one event (prompt, rpm, speed or fuel) per transfer,
// when o_out_valid is high and i_out_stall is low.
// Throughput: one character per cycle. A CR or LF that ends a non-empty line
// goes into a two-entry line queue. o_in_stall rises only while that queue is
// full, and then every character waits, not only line ends.
// The CR or LF that ends a line is registered in the line queue, and the
// line's event then in the output register, which drives the output.
// Lines that give no event drain from the queue even while the output waits.
// Reset (synchronous, active low) empties the queue, drops any partial line
// and clears o_out_valid. While the receiver stalls, the event holds.
// ---------------------------------------------------------------------------
module obd_response_line_parser_core
    import obdp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_q_valid;
    t_line w_line_in;
    t_line w_line_out;

    obdp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_data   (i_in_data),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_line   (w_line_in)
    );

    obdp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_line  (w_line_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_line  (w_line_out)
    );

    obdp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_line    (w_line_out),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_data    (o_out_data)
    );

endmodule

// ===== rtl/core/obdp_checker.sv =====
// ---------------------------------------------------------------------------
// obdp_checker
// Port-level checks on the parser's output channel, bound to the top level.
// ---------------------------------------------------------------------------
module obdp_checker
    import obdp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_prompt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_kind == EV_PROMPT
            |-> o_out_data.event_value == 14'd0)
        else $error("prompt event with nonzero value");

    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_kind == EV_SPEED
                        || o_out_data.event_kind == EV_FUEL)
            |-> o_out_data.event_value[13:8] == 6'd0)
        else $error("speed or fuel value exceeds one byte");

    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) && i_rst_n && $past(i_rst_n, 2) == 1'b0 |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind obd_response_line_parser_core obdp_checker u_obdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/obdp_event_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// obdp_event_checker
// Watches both channels of the OBD response line parser. It keeps its own
// copy of the line store and decodes each finished line into the event it
// should give. Every event the block hands out is compared field by field
// with the oldest predicted one.
// ---------------------------------------------------------------------------
module obdp_event_checker
    import obdp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_events_waiting,
    output int        o_events_checked
);

    logic [7:0] line_head [HEAD_N];
    logic [9:0] line_len;
    t_out_item  predicted_events [$];
    int         errors;
    int         checked;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    // byte at pos of the current line, accepted the way strtol would take it
    function automatic logic decode_pair(input int pos, output logic [7:0] val);
        logic [7:0] c0;
        logic [7:0] c1;
        int         hi;
        int         lo;
        val = 8'd0;
        if (pos + 2 > int'(line_len) || pos + 2 > HEAD_N) return 1'b0;
        c0 = line_head[pos];
        c1 = line_head[pos + 1];
        hi = hex_nibble(c0);
        lo = hex_nibble(c1);
        if (hi >= 0 && lo >= 0) begin
            val = 8'(hi * 16 + lo);
            return 1'b1;
        end
        if ((c0 == CH_SPACE || c0 == CH_PLUS) && lo >= 0) begin
            val = 8'(lo);
            return 1'b1;
        end
        if (c0 == CH_MINUS && c1 == CH_ZERO) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic line_event(input logic live, output t_out_item ev);
        logic [7:0] pid;
        logic [7:0] a;
        logic [7:0] b;
        ev = '0;
        if (line_len == 10'd1 && line_head[0] == CH_PROMPT) begin
            ev.event_kind  = EV_PROMPT;
            ev.event_value = 14'd0;
            return 1'b1;
        end
        if (!live || line_head[0] != CH_FOUR) return 1'b0;
        if (!decode_pair(2, pid)) return 1'b0;
        if (pid == PID_RPM) begin
            if (line_len < 10'd8 || !decode_pair(4, a) || !decode_pair(6, b)) return 1'b0;
            ev.event_kind  = EV_RPM;
            ev.event_value = 14'({a, b} >> 2);
            return 1'b1;
        end
        if (pid == PID_SPEED || pid == PID_FUEL) begin
            if (line_len < 10'd6 || !decode_pair(4, a)) return 1'b0;
            ev.event_kind  = (pid == PID_SPEED) ? EV_SPEED : EV_FUEL;
            ev.event_value = 14'(a);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic absorb_char(input t_in_item item);
        t_out_item ev;
        if (item.rx_char == CH_CR || item.rx_char == CH_LF) begin
            if (line_len != 10'd0) begin
                if (line_event(item.link_live, ev)) predicted_events.push_back(ev);
                line_len = 10'd0;
            end
        end else if (item.rx_char >= CH_PRT_LO && item.rx_char <= CH_PRT_HI) begin
            // past capacity the character is dropped
            if (line_len < 10'(LINE_CAP - 1)) begin
                if (line_len < 10'(HEAD_N)) line_head[line_len[HEAD_IW-1:0]] = item.rx_char;
                line_len = line_len + 10'd1;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] event mismatch: %s", $time, msg);
    endtask

    task automatic check_event(input t_out_item got);
        t_out_item want;
        checked++;
        if (predicted_events.size() == 0) begin
            report_mismatch($sformatf("kind %0d value %0d with no event predicted",
                                      got.event_kind, got.event_value));
        end else begin
            want = predicted_events.pop_front();
            if (got.event_kind !== want.event_kind)
                report_mismatch($sformatf("kind %0d, predicted %0d",
                                          got.event_kind, want.event_kind));
            if (got.event_value !== want.event_value)
                report_mismatch($sformatf("value %0d, predicted %0d (kind %0d)",
                                          got.event_value, want.event_value,
                                          want.event_kind));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_len = 10'd0;
            predicted_events.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_event(i_out_data);
            if (i_in_valid && !i_in_stall) absorb_char(i_in_data);
        end
        o_fail_count     <= errors;
        o_events_waiting <= predicted_events.size();
        o_events_checked <= checked;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Character stimulus for the OBD response line parser: a directed set of
// lines, then random replies, prompts, text and noise bytes, with random
// gaps on the sender and random stalls on the receiver.
// ---------------------------------------------------------------------------
module tb;
    import obdp_pkg::*;

    localparam int RUN_CHARS   = 1350;
    localparam int DRAIN_EVERY = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_stall = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    int         fail_count;
    int         events_waiting;
    int         events_checked;
    bit         calm        = 1'b0;
    int         cycles      = 0;
    int         stall_left  = 0;
    int         chars_taken = 0;
    int         lines_sent  = 0;
    logic [7:0] line_buf [$];

    always #4 i_clk = ~i_clk;

    obd_response_line_parser_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    obdp_event_checker u_event_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_in_data        (i_in_data),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_out_data       (o_out_data),
        .o_fail_count     (fail_count),
        .o_events_waiting (events_waiting),
        .o_events_checked (events_checked)
    );

    // mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic int sender_gap();
        if (calm || $urandom_range(0, 99) < 65) return 0;
        return idle_len();
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (calm || $urandom_range(0, 99) < 70) begin
            i_out_stall <= 1'b0;
        end else begin
            stall_left  <= idle_len() - 1;
            i_out_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding", cycles, events_waiting);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    // control or high byte that the parser skips
    function automatic logic [7:0] skipped_byte();
        logic [7:0] b;
        if ($urandom_range(0, 1)) begin
            b = 8'($urandom_range(0, 31));
            if (b == CH_CR || b == CH_LF) b = 8'h1B;
            return b;
        end
        return 8'($urandom_range(127, 255));
    endfunction

    task automatic send_char(input logic [7:0] c, input logic live);
        int       gap;
        t_in_item item;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item.rx_char   = c;
        item.link_live = live;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (c == CH_CR || c == CH_LF || (c >= CH_PRT_LO && c <= CH_PRT_HI)) chars_taken++;
        if (c == CH_CR || c == CH_LF) lines_sent++;
    endtask

    task automatic send_line(input string s, input logic live, input logic [7:0] term);
        for (int k = 0; k < s.len(); k++) send_char(s[k], live);
        send_char(term, live);
    endtask

    // sender holds off until every predicted event has come out
    task automatic drain_events();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (events_waiting != 0) @(posedge i_clk);
    endtask

    task automatic push_pair(input logic [7:0] val);
        int r;
        r = $urandom_range(0, 99);
        if (r < 84) begin
            line_buf.push_back(hex_char(val[7:4]));
            line_buf.push_back(hex_char(val[3:0]));
        end else if (r < 89) begin
            line_buf.push_back(CH_SPACE);
            line_buf.push_back(hex_char(val[3:0]));
        end else if (r < 93) begin
            line_buf.push_back(CH_PLUS);
            line_buf.push_back(hex_char(val[3:0]));
        end else if (r < 96) begin
            line_buf.push_back(CH_MINUS);
            line_buf.push_back(CH_ZERO);
        end else begin
            line_buf.push_back(printable());
            line_buf.push_back(printable());
        end
    endtask

    task automatic send_random_line();
        int         pick;
        int         r;
        int         n_data;
        logic       live;
        logic       noise;
        logic [7:0] pid;
        line_buf.delete();
        live  = ($urandom_range(0, 9) != 0);
        pick  = $urandom_range(0, 99);
        noise = 1'b0;
        if (pick < 60) begin
            line_buf.push_back(CH_FOUR);
            if ($urandom_range(0, 7) != 0) line_buf.push_back(CH_ZERO + 8'd1);
            else line_buf.push_back(printable());
            r = $urandom_range(0, 9);
            if (r < 4) pid = PID_RPM;
            else if (r < 6) pid = PID_SPEED;
            else if (r < 8) pid = PID_FUEL;
            else pid = 8'($urandom);
            push_pair(pid);
            n_data = (pid == PID_RPM) ? 2 : 1;
            if ($urandom_range(0, 5) == 0) n_data += $urandom_range(1, 2);
            repeat (n_data) push_pair(8'($urandom));
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, line_buf.size() - 1))
                void'(line_buf.pop_back());
            // overlong tail, runs past the line capacity now and then
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 70))
                line_buf.push_back(printable());
        end else if (pick < 70) begin
            line_buf.push_back(CH_PROMPT);
            if ($urandom_range(0, 4) == 0) line_buf.push_back(printable());
        end else if (pick < 82) begin
            repeat ($urandom_range(0, 12)) line_buf.push_back(printable());
        end else begin
            noise = 1'b1;
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom));
        end
        if ($urandom_range(0, 19) == 0 && line_buf.size() > 0)
            line_buf.insert($urandom_range(0, line_buf.size() - 1), skipped_byte());
        foreach (line_buf[k]) send_char(line_buf[k], ($urandom_range(0, 19) == 0) ? !live : live);
        if (!noise || $urandom_range(0, 1)) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                send_char(CH_CR, live);
            end else if (r < 8) begin
                send_char(CH_LF, live);
            end else begin
                send_char(CH_CR, live);
                send_char(CH_LF, live);
            end
        end
    endtask

    initial begin
        string long_s;
        int    next_drain;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_line(">", 1'b0, CH_CR);
        send_char(CH_LF, 1'b0);
        send_line("410C0000", 1'b1, CH_LF);
        send_line("410CFFFF", 1'b1, CH_CR);
        send_line("410D00", 1'b1, CH_CR);
        send_line("410DFF", 1'b1, CH_LF);
        send_line("412F7f", 1'b1, CH_CR);
        send_line("410C 1+a", 1'b1, CH_CR);
        send_line("410D-0", 1'b1, CH_CR);
        send_line("410D-1", 1'b1, CH_CR);
        send_line("410d8G", 1'b1, CH_CR);
        send_line("410C12", 1'b1, CH_CR);
        send_line("410D1", 1'b1, CH_CR);
        send_line("4105AB", 1'b1, CH_CR);
        send_line("410C1234", 1'b0, CH_CR);
        send_line("", 1'b1, CH_LF);
        send_line(">>", 1'b1, CH_CR);
        send_line("5", 1'b1, CH_CR);
        // skipped bytes inside a fuel reply
        send_char(CH_FOUR, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'h09, 1'b1);
        send_char(CH_ZERO + 8'd1, 1'b1);
        send_char(8'h7F, 1'b1);
        send_char(8'h80, 1'b1);
        send_char(8'hFF, 1'b1);
        send_line("2f80", 1'b1, CH_CR);
        long_s = "410D7B";
        repeat (70) long_s = {long_s, "x"};
        send_line(long_s, 1'b1, CH_LF);
        send_line("412FA5", 1'b1, CH_CR);
        drain_events();

        next_drain = chars_taken + DRAIN_EVERY;
        while (chars_taken < RUN_CHARS) begin
            if ($urandom_range(0, 9) == 0) calm <= !calm;
            if (chars_taken >= next_drain) begin
                drain_events();
                next_drain += DRAIN_EVERY;
            end
            send_random_line();
        end
        drain_events();
        repeat (10) @(posedge i_clk);

        $display("sent %0d kept characters over %0d line ends: replies, prompts, text, noise",
                 chars_taken, lines_sent);
        $display("checked %0d events, including short, malformed and overlong lines",
                 events_checked);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== obd_response_line_parser_core.f =====
rtl/core/obdp_pkg.sv
rtl/core/obdp_front.sv
rtl/core/obdp_fifo.sv
rtl/core/obdp_back.sv
rtl/core/obd_response_line_parser_core.sv
rtl/core/obdp_checker.sv
tb/sv/obdp_event_checker.sv
tb/sv/tb.sv
